// ----- design/idet_pkg.sv -----
// Shared constants, types and the permutation table of the determinant block.
`timescale 1ns / 1ps
package idet_pkg;

  localparam int MAX_SIZE  = 4;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 3;
  localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ROW_W     = $clog2(MAX_SIZE);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int NUM_PERMS = 24;
  localparam int PERM_W    = $clog2(NUM_PERMS);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_MULT,
    ST_ACCUM,
    ST_DONE
  } state_e;

  // Operations of the shared multiply-accumulate unit.
  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_CLR,
    MAC_LOAD,
    MAC_MUL,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef struct packed {
    mac_op_e op;
  } mac_ctrl_t;

  // Each entry is {negative, column of row 3, row 2, row 1, row 0}.
  // Permutations of two columns come first, then those of three, so the
  // leading n! entries cover an n by n matrix with the right signs.
  localparam logic [8:0] PERM_TABLE [NUM_PERMS] = '{
    {1'b0, 2'd3, 2'd2, 2'd1, 2'd0},
    {1'b1, 2'd3, 2'd2, 2'd0, 2'd1},
    {1'b1, 2'd3, 2'd1, 2'd2, 2'd0},
    {1'b0, 2'd3, 2'd0, 2'd2, 2'd1},
    {1'b0, 2'd3, 2'd1, 2'd0, 2'd2},
    {1'b1, 2'd3, 2'd0, 2'd1, 2'd2},
    {1'b1, 2'd2, 2'd3, 2'd1, 2'd0},
    {1'b0, 2'd1, 2'd3, 2'd2, 2'd0},
    {1'b0, 2'd2, 2'd1, 2'd3, 2'd0},
    {1'b1, 2'd1, 2'd2, 2'd3, 2'd0},
    {1'b0, 2'd2, 2'd3, 2'd0, 2'd1},
    {1'b1, 2'd0, 2'd3, 2'd2, 2'd1},
    {1'b1, 2'd2, 2'd0, 2'd3, 2'd1},
    {1'b0, 2'd0, 2'd2, 2'd3, 2'd1},
    {1'b1, 2'd1, 2'd3, 2'd0, 2'd2},
    {1'b0, 2'd0, 2'd3, 2'd1, 2'd2},
    {1'b0, 2'd1, 2'd0, 2'd3, 2'd2},
    {1'b1, 2'd0, 2'd1, 2'd3, 2'd2},
    {1'b1, 2'd2, 2'd1, 2'd0, 2'd3},
    {1'b0, 2'd1, 2'd2, 2'd0, 2'd3},
    {1'b0, 2'd2, 2'd0, 2'd1, 2'd3},
    {1'b1, 2'd0, 2'd2, 2'd1, 2'd3},
    {1'b1, 2'd1, 2'd0, 2'd2, 2'd3},
    {1'b0, 2'd0, 2'd1, 2'd2, 2'd3}
  };

  // Column picked in a given row by a given permutation.
  function automatic logic [ROW_W-1:0] perm_col(logic [PERM_W-1:0] k, logic [ROW_W-1:0] row);
    logic [8:0] entry;
    entry = PERM_TABLE[k];
    return entry[row*ROW_W +: ROW_W];
  endfunction

  function automatic logic perm_neg(logic [PERM_W-1:0] k);
    logic [8:0] entry;
    entry = PERM_TABLE[k];
    return entry[8];
  endfunction

  // Number of permutations to walk for a given matrix size.
  function automatic logic [PERM_W-1:0] perm_count(logic [SIZE_W-1:0] n);
    logic [PERM_W-1:0] cnt;
    case (n)
      3'd2:    cnt = PERM_W'(2);
      3'd3:    cnt = PERM_W'(6);
      default: cnt = PERM_W'(NUM_PERMS);
    endcase
    return cnt;
  endfunction

endpackage

// ----- design/idet_if.sv -----
// Valid/ready channel interfaces for elements, results and configuration.
`timescale 1ns / 1ps
interface idet_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface idet_det_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] determinant;
  modport source (output valid, output determinant, input ready);
  modport sink   (input valid, input determinant, output ready);
endinterface

interface idet_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] matrix_size;
  modport source (output valid, output matrix_size, input ready);
  modport sink   (input valid, input matrix_size, output ready);
endinterface

// ----- design/idet_ram.sv -----
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module idet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/idet_mac.sv -----
// Shared multiply-accumulate unit: running product and signed accumulator.
`timescale 1ns / 1ps
module idet_mac import idet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] data_i,
  output logic [DATA_W-1:0] acc_o
);

  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] mul_res;

  // Low word of the product, which is all that modulo 2^32 needs.
  assign mul_res = prod_q * data_i;

  // Operation select.
  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    case (ctrl_i.op)
      MAC_CLR:  acc_d  = '0;
      MAC_LOAD: prod_d = data_i;
      MAC_MUL:  prod_d = mul_res;
      MAC_ADD:  acc_d  = acc_q + prod_q;
      MAC_SUB:  acc_d  = acc_q - prod_q;
      default: begin
        prod_d = prod_q;
        acc_d  = acc_q;
      end
    endcase
  end

  // The product is payload; the accumulator comes out of reset at zero.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- design/integer_matrix_determinant.sv -----
// Top level: loads a square matrix and computes its determinant modulo 2^32.
//
// Usage: write matrix_size (2 to 4; smaller values act as 2, larger as 4) on
// cfg_i while the block is idle; a write also drops any partly loaded matrix.
// Then send n*n elements on elem_i in row-major order, one beat per cycle.
// After the last element the block stops taking beats and walks all n!
// permutations on one shared multiply-accumulate unit: per permutation each
// of n rows is read from memory and then multiplied into the product, after
// which the product is added to or subtracted from the accumulator; once all
// are done the result is handed to the output register. The single read
// port of the element memory and the one multiplier set this order of steps.
// The determinant then appears on det_o and is held until taken; the next
// matrix may already load while it waits, but its result is not registered
// until the previous beat has left. At reset the size returns to 2, the load
// count and accumulator to zero, and no result is pending. The element
// memory has no reset: every entry is written before it is read.
`timescale 1ns / 1ps
module integer_matrix_determinant import idet_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  idet_cfg_if.sink   cfg_i,
  idet_elem_if.sink  elem_i,
  idet_det_if.source det_o
);

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  load_count_q, load_count_d;
  logic [PERM_W-1:0] perm_q, perm_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] det_q, det_d;

  logic [SIZE_W-1:0] eff_n;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  count_next;
  logic [PERM_W-1:0] num_perms;
  logic [ROW_W-1:0]  last_row;
  logic              elem_beat;
  logic              cfg_beat;
  logic              out_beat;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] acc;
  mac_ctrl_t         mac_ctrl;

  // Effective size, saturated to the supported range.
  always_comb begin
    if (size_q < SIZE_W'(2)) begin
      eff_n = SIZE_W'(2);
    end else if (size_q > SIZE_W'(MAX_SIZE)) begin
      eff_n = SIZE_W'(MAX_SIZE);
    end else begin
      eff_n = size_q;
    end
  end

  assign total      = CNT_W'(CNT_W'(eff_n) * CNT_W'(eff_n));
  assign count_next = CNT_W'(load_count_q + CNT_W'(1));
  assign num_perms  = perm_count(eff_n);
  assign last_row   = ROW_W'(eff_n - SIZE_W'(1));

  // Handshakes.
  assign cfg_i.ready  = 1'b1;
  assign elem_i.ready = (state_q == ST_LOAD);
  assign cfg_beat     = cfg_i.valid && cfg_i.ready;
  assign elem_beat    = elem_i.valid && elem_i.ready;
  assign out_beat     = out_valid_q && det_o.ready;
  assign ram_we       = elem_beat;

  // Element address of the current row under the current permutation.
  assign ram_raddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(eff_n))
                   + ADDR_W'(perm_col(perm_q, row_q));

  // Sequencer: next state and unit control.
  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    load_count_d = load_count_q;
    perm_d       = perm_q;
    row_d        = row_q;
    out_valid_d  = out_valid_q;
    det_d        = det_q;
    mac_ctrl.op  = MAC_NOP;

    if (out_beat) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (elem_beat) begin
          if (count_next == total) begin
            load_count_d = '0;
            perm_d       = '0;
            row_d        = '0;
            mac_ctrl.op  = MAC_CLR;
            state_d      = ST_FETCH;
          end else begin
            load_count_d = count_next;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_MULT;
      end
      ST_MULT: begin
        mac_ctrl.op = (row_q == '0) ? MAC_LOAD : MAC_MUL;
        if (row_q == last_row) begin
          row_d   = '0;
          state_d = ST_ACCUM;
        end else begin
          row_d   = row_q + ROW_W'(1);
          state_d = ST_FETCH;
        end
      end
      ST_ACCUM: begin
        mac_ctrl.op = perm_neg(perm_q) ? MAC_SUB : MAC_ADD;
        if (perm_q == num_perms - PERM_W'(1)) begin
          state_d = ST_DONE;
        end else begin
          perm_d  = perm_q + PERM_W'(1);
          state_d = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          det_d       = acc;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // A size write restarts loading.
    if (cfg_beat) begin
      size_d       = cfg_i.matrix_size;
      load_count_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      size_q       <= SIZE_W'(2);
      load_count_q <= '0;
      perm_q       <= '0;
      row_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      load_count_q <= load_count_d;
      perm_q       <= perm_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    det_q <= det_d;
  end

  assign det_o.valid       = out_valid_q;
  assign det_o.determinant = det_q;

  // Element memory.
  idet_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_count_q[ADDR_W-1:0]),
    .wdata_i (elem_i.element),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared multiply-accumulate unit.
  idet_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .data_i (ram_rdata),
    .acc_o  (acc)
  );

`ifndef SYNTHESIS
  // The last element of a matrix starts the permutation walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elem_beat && !cfg_beat && count_next == total) |=> (state_q == ST_FETCH))
    else $error("last element did not start the computation");

  // While loading, the count stays below the element total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (load_count_q < total))
    else $error("load count out of range");

  // The permutation walk stays within the n! entries of the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (perm_q < num_perms && row_q <= last_row))
    else $error("permutation or row index out of range");

  // A finished determinant is registered as soon as the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && det_q == $past(acc)))
    else $error("finished determinant not presented");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the integer matrix determinant block.
`timescale 1ns / 1ps
module tb_top;
  import idet_pkg::*;

  localparam int unsigned TOTAL_ITEMS   = 1750;
  // Covers the longest compute pass (4x4) with a margin on top of it.
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  typedef logic [DATA_W-1:0] word_t;

  // Tracks the loaded matrix, predicts determinants and checks them in order.
  class det_scoreboard;
    word_t       store [DEPTH];
    int unsigned fill;
    logic [2:0]  size_reg;
    word_t       expected_q [$];
    int unsigned errors;

    function new();
      fill     = 0;
      size_reg = 3'd2;
      errors   = 0;
    endfunction

    // Sizes below two act as two, sizes above the maximum saturate.
    function int unsigned side_of(logic [2:0] v);
      if (v < 3'd2) return 2;
      if (v > 3'(MAX_SIZE)) return MAX_SIZE;
      return 32'(v);
    endfunction

    function word_t det2(word_t a, word_t b, word_t c, word_t d);
      return a * d - b * c;
    endfunction

    // Expansion along the first row of a row-major 3x3 matrix.
    function word_t det3(word_t m [9]);
      word_t sum;
      sum = m[0] * det2(m[4], m[5], m[7], m[8]);
      sum = sum - m[1] * det2(m[3], m[5], m[6], m[8]);
      sum = sum + m[2] * det2(m[3], m[4], m[6], m[7]);
      return sum;
    endfunction

    // Expansion along the first row of the stored 4x4 matrix.
    function word_t det4();
      word_t       sub [9];
      word_t       sum;
      word_t       term;
      int unsigned idx;
      sum = '0;
      for (int col = 0; col < 4; col++) begin
        idx = 0;
        for (int r = 1; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            if (c != col) begin
              sub[idx] = store[r*4 + c];
              idx++;
            end
          end
        end
        term = store[col] * det3(sub);
        if (col % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      return sum;
    endfunction

    function word_t determinant(int unsigned n);
      word_t m9 [9];
      case (n)
        2: return det2(store[0], store[1], store[2], store[3]);
        3: begin
          for (int i = 0; i < 9; i++) m9[i] = store[i];
          return det3(m9);
        end
        default: return det4();
      endcase
    endfunction

    // A size write also drops any partly loaded matrix.
    function void write_size(logic [2:0] v);
      size_reg = v;
      fill     = 0;
    endfunction

    function void note_element(word_t e);
      int unsigned total;
      total = side_of(size_reg) * side_of(size_reg);
      if (fill >= total) fill = 0;
      store[fill] = e;
      fill++;
      if (fill == total) begin
        expected_q.push_back(determinant(side_of(size_reg)));
        fill = 0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_determinant(word_t got);
      word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected determinant %h", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) report($sformatf("determinant %h, expected %h", got, want));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 64;
  int unsigned sent = 0;
  logic        hold_trigger = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  det_scoreboard sb = new();

  idet_cfg_if  cfg_bus ();
  idet_elem_if elem_bus ();
  idet_det_if  det_bus ();

  integer_matrix_determinant i_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .elem_i (elem_bus),
    .det_o  (det_bus)
  );

  always #6 clk = ~clk;

  // Result receiver: random stalls, plus a long hold-off when triggered.
  always @(posedge clk) begin
    if (!rst_ni) begin
      det_bus.ready <= 1'b0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen     <= hold_trigger;
      hold_left     <= HOLD_CYCLES;
      det_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      det_bus.ready <= 1'b0;
    end else begin
      det_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Observe every beat on all three channels.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (det_bus.valid && det_bus.ready) sb.check_determinant(det_bus.determinant);
      if (elem_bus.valid && elem_bus.ready) sb.note_element(elem_bus.element);
      if (cfg_bus.valid && cfg_bus.ready) sb.write_size(cfg_bus.matrix_size);
    end
  end

  // Mix of extremes, small values that give meaningful determinants, and noise.
  function automatic word_t pick_element();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5, 6: return $urandom_range(8) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_element(input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      elem_bus.valid <= 1'b0;
      @(posedge clk);
    end
    elem_bus.valid   <= 1'b1;
    elem_bus.element <= value;
    do @(posedge clk); while (!elem_bus.ready);
    sent++;
  endtask

  // Stop offering elements and wait until every predicted result has come.
  task automatic wait_drained();
    elem_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [2:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.matrix_size <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [2:0]  size_val;
    int unsigned n;
    int unsigned seg;
    int unsigned phase;
    elem_bus.valid      <= 1'b0;
    elem_bus.element    <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.matrix_size <= 3'd2;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset size of two with extreme entries.
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7fff_ffff);
    send_element(32'hffff_ffff);
    send_element(32'd1);
    send_element(32'h8000_0000);
    send_element(32'hffff_ffff);
    // A partly loaded matrix is dropped by the size write.
    send_element(32'd5);
    send_element(32'h7fff_ffff);
    send_element(32'd9);
    write_size(3'd3);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    send_element(32'hffff_ffff);
    send_element(32'd0);
    send_element(32'd1);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    send_element(32'hffff_ffff);
    send_element(32'd0);
    // Size zero acts as two.
    write_size(3'd0);
    repeat (4) send_element(32'h8000_0000);

    // Random matrices over all size values, in three idle regimes.
    seg   = 0;
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      if (phase == 0 && sent >= TOTAL_ITEMS / 3) begin
        phase         = 1;
        send_idle_pct = 64;
        recv_idle_pct = 30;
      end else if (phase == 1 && sent >= 2 * TOTAL_ITEMS / 3) begin
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver hold-off while small matrices keep coming in.
        write_size(3'd2);
        hold_trigger <= ~hold_trigger;
        repeat (24) send_element(pick_element());
      end
      size_val = (seg < 8) ? 3'(seg) : 3'($urandom_range(7));
      write_size(size_val);
      n = sb.side_of(size_val);
      repeat ($urandom_range(1, 5)) begin
        repeat (n * n) send_element(pick_element());
      end
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, n * n - 1)) send_element(pick_element());
      end
      seg++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d determinants never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT at %0t", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
